FILE: hdl/stsp_pkg.sv
`default_nettype none
package stsp_pkg;
  localparam int unsigned NodeW = 4;
  localparam int unsigned SlotW = 7;
  localparam int unsigned CommW = 3;
  localparam int unsigned CostW = 16;
  localparam int unsigned DistW = 20;
  localparam logic [DistW-1:0] DistMax = 20'hFFFFF;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_e;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgEdgeCount = 1'b1;

  typedef struct packed {
    logic             op;
    logic [SlotW-1:0] edge_slot;
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
    logic [CommW-1:0] commodity;
    logic [CostW-1:0] edge_cost;
    logic [NodeW-1:0] target_node;
  } in_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [DistW-1:0] distance;
    logic             reachable;
    logic             last;
  } out_t;
endpackage
`default_nettype wire

FILE: hdl/stsp_if.sv
`default_nettype none
interface stsp_in_if;
  logic           valid;
  logic           ready;
  stsp_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stsp_out_if;
  logic           valid;
  logic           ready;
  stsp_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/stsp_ram.sv
`default_nettype none
module stsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hdl/stsp_front.sv
`default_nettype none
// Accepts requests into a two-entry queue.
module stsp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  stsp_in_if.sink            in_if,
  output logic               q_valid_o,
  output stsp_pkg::in_t      q_data_o,
  input  wire logic          q_pop_i
);
  stsp_pkg::in_t q_mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = q_mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_q] <= in_if.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/stsp_back.sv
`default_nettype none
// Edge stores, Dijkstra sequencer and output register.
module stsp_back #(
  parameter int unsigned MaxNodes = 16,
  parameter int unsigned MaxEdges = 128,
  parameter int unsigned MaxComm  = 8,
  parameter int unsigned CostBits = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic [4:0] node_count_i,
  input  wire logic [7:0] edge_count_i,
  input  wire logic     q_valid_i,
  input  stsp_pkg::in_t q_data_i,
  output logic          q_pop_o,
  stsp_out_if.source    out_if
);
  localparam int unsigned NW  = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned NCW = $clog2(MaxNodes + 1);
  localparam int unsigned EW  = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned ECW = $clog2(MaxEdges + 1);
  localparam int unsigned CW  = (MaxComm > 1) ? $clog2(MaxComm) : 1;
  localparam int unsigned DW  = stsp_pkg::DistW;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INIT   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_ERD    = 7'b0001000,
    S_EUPD   = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_WAIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [NCW-1:0] nodes_q;
  logic [ECW-1:0] edges_q;
  logic [CW-1:0]  comm_q;
  logic [NW-1:0]  idx_q;
  logic [EW-1:0]  eidx_q;
  logic [ECW-1:0] ecnt_q;
  logic [NW-1:0]  best_q;
  logic           found_q;
  logic [DW-1:0]  bdist_q;
  logic [DW-1:0]  dist_q [MaxNodes];
  logic [MaxNodes-1:0] fin_q, set_q;

  // Load path writes.
  stsp_pkg::in_t d;
  logic [EW-1:0] ld_slot;
  logic [CW-1:0] ld_comm;
  logic          ld_we;
  assign d       = q_data_i;
  assign ld_slot = EW'(d.edge_slot % MaxEdges);
  assign ld_comm = CW'(d.commodity % MaxComm);
  assign ld_we   = (state_q == S_IDLE) && q_valid_i && (d.op == stsp_pkg::OP_LOAD);

  logic [stsp_pkg::NodeW-1:0] tail_rd, head_rd;
  logic [CostBits-1:0]        cost_rd;
  logic [EW+CW-1:0]           cost_wa, cost_ra;
  assign cost_wa = {ld_slot, ld_comm};
  assign cost_ra = {eidx_q, comm_q};

  stsp_ram #(.Width(stsp_pkg::NodeW), .Depth(MaxEdges)) u_tail (
    .clk_i, .we_i(ld_we), .waddr_i(ld_slot), .wdata_i(d.from_node),
    .raddr_i(eidx_q), .rdata_o(tail_rd));
  stsp_ram #(.Width(stsp_pkg::NodeW), .Depth(MaxEdges)) u_head (
    .clk_i, .we_i(ld_we), .waddr_i(ld_slot), .wdata_i(d.to_node),
    .raddr_i(eidx_q), .rdata_o(head_rd));
  stsp_ram #(.Width(CostBits), .Depth(MaxEdges*MaxComm)) u_cost (
    .clk_i, .we_i(ld_we), .waddr_i(cost_wa), .wdata_i(CostBits'(d.edge_cost)),
    .raddr_i(cost_ra), .rdata_o(cost_rd));

  // Relaxation of one edge, read data arrives in S_EUPD.
  logic [DW:0]   sum;
  logic [DW-1:0] sum_sat;
  logic          t_ok, relax;
  assign sum     = {1'b0, bdist_q} + (DW+1)'(cost_rd);
  assign sum_sat = sum[DW] ? stsp_pkg::DistMax : sum[DW-1:0];
  assign t_ok    = ({{(NCW > 4 ? NCW-4 : 0){1'b0}}, tail_rd} < (NCW > 4 ? NCW : 5)'(nodes_q))
                   && (MaxNodes >= 16 || tail_rd < 4'(MaxNodes));
  logic [NW-1:0] tidx;
  assign tidx  = NW'(tail_rd);
  assign relax = (head_rd == 4'(best_q)) && t_ok &&
                 (!fin_q[tidx] || sum_sat < dist_q[tidx]);

  logic scan_better;
  assign scan_better = !set_q[idx_q] && fin_q[idx_q] &&
                       (!found_q || dist_q[idx_q] < bdist_q);

  logic last_node;
  assign last_node = ({1'b0, idx_q} + NCW'(1)) == nodes_q;

  logic [4:0] nsat;
  logic [7:0] esat;
  assign nsat = (32'(node_count_i) > MaxNodes) ? 5'(MaxNodes) : node_count_i;
  assign esat = (32'(edge_count_i) > MaxEdges) ? 8'(MaxEdges) : edge_count_i;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (q_valid_i && d.op == stsp_pkg::OP_RUN) state_d = S_INIT;
      S_INIT: state_d = (nodes_q == '0) ? S_IDLE : S_SCAN;
      S_SCAN: if (last_node) state_d = (found_q || scan_better) ? S_ERD : S_EMIT;
      S_ERD:  state_d = (ecnt_q == '0) ? S_SCAN : S_EUPD;
      S_EUPD: state_d = (ecnt_q == '0) ? S_SCAN : S_EUPD;
      S_EMIT: state_d = S_WAIT;
      S_WAIT: if (out_if.ready) state_d = last_node ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  logic [stsp_pkg::NodeW-1:0] tgt_q;

  // Target seeded as the only finite node when it is in use.
  logic [MaxNodes-1:0] tgt_hot;
  assign tgt_hot = ({{(NCW > 4 ? NCW-4 : 0){1'b0}}, tgt_q} < (NCW > 4 ? NCW : 5)'(nodes_q))
                   ? (MaxNodes'(1) << tgt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_if.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EMIT) out_if.valid <= 1'b1;
      else if (out_if.ready) out_if.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        nodes_q <= NCW'(nsat);
        edges_q <= ECW'(esat);
        comm_q  <= CW'(d.commodity % MaxComm);
        tgt_q   <= d.target_node;
      end
      S_INIT: begin
        fin_q   <= tgt_hot;
        set_q   <= '0;
        idx_q   <= '0;
        found_q <= 1'b0;
        for (int i = 0; i < MaxNodes; i++) dist_q[i] <= '0;
      end
      S_SCAN: begin
        if (scan_better) begin
          best_q  <= idx_q;
          bdist_q <= dist_q[idx_q];
          found_q <= 1'b1;
        end
        if (last_node) begin
          idx_q <= '0;
          if (found_q || scan_better) begin
            set_q[scan_better ? idx_q : best_q] <= 1'b1;
            eidx_q <= '0;
            ecnt_q <= edges_q;
          end
        end else begin
          idx_q <= idx_q + NW'(1);
        end
      end
      S_ERD, S_EUPD: begin
        found_q <= 1'b0;
        if (state_q == S_EUPD && relax) begin
          dist_q[tidx] <= sum_sat;
          fin_q[tidx]  <= 1'b1;
        end
        if (ecnt_q != '0) begin
          ecnt_q <= ecnt_q - ECW'(1);
          eidx_q <= eidx_q + EW'(1);
        end
      end
      S_EMIT: begin
        out_if.data.node      <= 4'(idx_q);
        out_if.data.distance  <= fin_q[idx_q] ? dist_q[idx_q] : '0;
        out_if.data.reachable <= fin_q[idx_q];
        out_if.data.last      <= last_node;
      end
      S_WAIT: if (out_if.ready && !last_node) idx_q <= idx_q + NW'(1);
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/single_target_shortest_path_top.sv
// Loads pass through a two-entry request queue and are written only while idle.
// A run has a setup step, then for each settled node a scan over node_count
// nodes plus a pass over edge_count edges, a closing scan, then one result
// per node through the S_EMIT and S_WAIT states of the back end sequencer.
// One request is processed at a time; results leave through a register.
// rst_ni is asynchronous active low; edge stores are not cleared by reset.
`default_nettype none
module single_target_shortest_path_top #(
  parameter int unsigned MAX_NODES       = 16,
  parameter int unsigned MAX_EDGES       = 128,
  parameter int unsigned MAX_COMMODITIES = 8,
  parameter int unsigned COST_BITS       = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  stsp_in_if.sink         in_if,
  stsp_out_if.source      out_if
);
  // Configuration registers.
  logic [4:0] node_count_q;
  logic [7:0] edge_count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 5'd16;
      edge_count_q <= 8'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == stsp_pkg::CfgNodeCount) node_count_q <= cfg_data_i[4:0];
      else edge_count_q <= cfg_data_i;
    end
  end

  // Front queue to back sequencer.
  logic          q_valid, q_pop;
  stsp_pkg::in_t q_data;

  stsp_front u_front (
    .clk_i, .rst_ni, .in_if,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop));

  stsp_back #(
    .MaxNodes(MAX_NODES), .MaxEdges(MAX_EDGES),
    .MaxComm(MAX_COMMODITIES), .CostBits(COST_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .node_count_i(node_count_q), .edge_count_i(edge_count_q),
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .out_if);
endmodule
`default_nettype wire

FILE: hdl/stsp_checker.sv
`default_nettype none
module stsp_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic [3:0] out_node
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_node))
    else $error("result dropped");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> !out_valid)
    else $error("back-to-back result");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |-> ##2 (out_valid && out_node == $past(out_node, 2) + 4'd1)
    || !out_valid)
    else $error("node order");
endmodule

bind single_target_shortest_path_top stsp_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_last(out_if.data.last), .out_node(out_if.data.node));
`default_nettype wire
